// ===== rtl/core/bhg_pkg.sv =====
package bhg_pkg;

    // Default width of the wrapping millisecond clock.
    localparam int TIME_BITS_DEF = 32;

    // Configuration register widths and reset values.
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int TIMER_BITS     = 16;
    localparam int AP_HOLD_BITS   = 6;

    localparam logic [TIMER_BITS-1:0]   DEBOUNCE_RST  = 16'd150;
    localparam logic [TIMER_BITS-1:0]   LONG_HOLD_RST = 16'd2000;
    localparam logic [TIMER_BITS-1:0]   WINDOW_RST    = 16'd5000;
    localparam logic [AP_HOLD_BITS-1:0] AP_HOLD_RST   = 6'd7;

    // Milliseconds per second, used to scale the access point hold time.
    localparam logic [9:0] MS_PER_S = 10'd1000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_HOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AP_HOLD   = 2'd3;

    // Input opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Blink burst requests.
    localparam logic [1:0] BLINK_NONE  = 2'd0;
    localparam logic [1:0] BLINK_FOUR  = 2'd1;
    localparam logic [1:0] BLINK_EIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WINDOW = 2'd1,
        MODE_HOLD   = 2'd2
    } mode_t;

    typedef struct packed {
        logic opcode;
        logic pin_pressed;
    } in_item_t;

    typedef struct packed {
        logic [1:0] gesture_mode;
        logic [1:0] blink_request;
        logic       start_ap;
        logic       edge_accepted;
    } out_item_t;

endpackage

// ===== rtl/core/button_hold_gesture_fsm.sv =====
// An accepted transaction waits in the input register until the result stage is free.
// Throughput: one transaction per cycle unless m_ready stalls the result stage; the
// state update is one pass of logic from input to result register, so nothing loops.
// Reset (aresetn low at a clock edge, synchronous): both stages empty, clock,
// last edge time and both countdowns zero, mode idle, registers at defaults.
module button_hold_gesture_fsm
    import bhg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers.
    logic [TIMER_BITS-1:0]   debounce_reg;
    logic [TIMER_BITS-1:0]   long_hold_reg;
    logic [TIMER_BITS-1:0]   window_reg;
    logic [AP_HOLD_BITS-1:0] ap_hold_reg;

    // Input stage and result stage.
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // Gesture state.
    logic [TIME_BITS-1:0]  now_reg,     now_next;
    logic [TIME_BITS-1:0]  last_reg,    last_next;
    mode_t                 mode_reg,    mode_next;
    logic [TIMER_BITS-1:0] window_left_reg, window_left_next;
    logic [TIMER_BITS-1:0] setup_left_reg,  setup_left_next;

    logic out_free;
    logic process;

    // The result stage can take a new value when it is empty or being drained.
    // The input stage accepts while it is empty or while the result stage is free.
    assign out_free = !out_valid_reg || m_ready;
    assign process  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_item_reg;

    // Access point hold time in ms; at most 63000, so it fits the timer width.
    logic [TIMER_BITS-1:0] ap_hold_ms;
    logic [TIMER_BITS-1:0] ap_arm;
    logic [TIMER_BITS-1:0] window_arm;
    logic [TIME_BITS-1:0]  gap;
    logic                  is_tick;
    logic                  edge_ok;
    logic                  window_expire;
    logic                  setup_expire;

    assign ap_hold_ms = TIMER_BITS'(ap_hold_reg) * TIMER_BITS'(MS_PER_S);
    // A zero length arms the countdown with one so that it runs out on the next tick.
    assign ap_arm     = (ap_hold_ms == '0) ? TIMER_BITS'(1) : ap_hold_ms;
    assign window_arm = (window_reg == '0) ? TIMER_BITS'(1) : window_reg;

    assign is_tick = (in_item_reg.opcode == OP_TICK);
    // The gap wraps with the clock and is taken as unsigned.
    assign gap     = now_reg - last_reg;
    assign edge_ok = !is_tick && (gap > TIME_BITS'(debounce_reg));

    // A countdown runs out on the tick that takes it from one to zero.
    assign window_expire = is_tick && (window_left_reg == TIMER_BITS'(1));
    assign setup_expire  = is_tick && (setup_left_reg == TIMER_BITS'(1));

    // Next mode.
    always_comb begin
        mode_next = mode_reg;
        if (is_tick) begin
            if (window_expire && mode_reg == MODE_WINDOW) begin
                mode_next = MODE_IDLE;
            end
        end else if (edge_ok) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (!in_item_reg.pin_pressed && gap > TIME_BITS'(long_hold_reg)) begin
                        mode_next = MODE_WINDOW;
                    end
                end
                MODE_WINDOW: begin
                    if (in_item_reg.pin_pressed) begin
                        mode_next = MODE_HOLD;
                    end
                end
                MODE_HOLD: begin
                    if (!in_item_reg.pin_pressed && gap > TIME_BITS'(ap_hold_ms)) begin
                        mode_next = MODE_IDLE;
                    end
                end
                default: mode_next = MODE_IDLE;
            endcase
        end
    end

    // Timers, clock and result fields.
    always_comb begin
        now_next         = now_reg;
        last_next        = last_reg;
        window_left_next = window_left_reg;
        setup_left_next  = setup_left_reg;
        out_item_next.gesture_mode  = mode_next;
        out_item_next.blink_request = BLINK_NONE;
        out_item_next.start_ap      = 1'b0;
        out_item_next.edge_accepted = 1'b0;

        if (is_tick) begin
            now_next = now_reg + TIME_BITS'(1);
            if (window_left_reg != '0) begin
                window_left_next = window_left_reg - TIMER_BITS'(1);
            end
            if (setup_left_reg != '0) begin
                setup_left_next = setup_left_reg - TIMER_BITS'(1);
            end
            // Expiry of the setup countdown only signals while still holding.
            if (setup_expire && mode_reg == MODE_HOLD) begin
                out_item_next.blink_request = BLINK_EIGHT;
            end
        end else if (edge_ok) begin
            out_item_next.edge_accepted = 1'b1;
            last_next = now_reg;
            if (mode_reg == MODE_IDLE && mode_next == MODE_WINDOW) begin
                out_item_next.blink_request = BLINK_FOUR;
                window_left_next = window_arm;
            end
            if (mode_reg == MODE_WINDOW && mode_next == MODE_HOLD) begin
                setup_left_next = ap_arm;
            end
            if (mode_reg == MODE_HOLD && mode_next == MODE_IDLE) begin
                out_item_next.start_ap = 1'b1;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RST;
            long_hold_reg <= LONG_HOLD_RST;
            window_reg    <= WINDOW_RST;
            ap_hold_reg   <= AP_HOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE:  debounce_reg  <= cfg_data;
                REG_LONG_HOLD: long_hold_reg <= cfg_data;
                REG_WINDOW:    window_reg    <= cfg_data;
                REG_AP_HOLD:   ap_hold_reg   <= cfg_data[AP_HOLD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid flags and gesture state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            now_reg         <= '0;
            last_reg        <= '0;
            mode_reg        <= MODE_IDLE;
            window_left_reg <= '0;
            setup_left_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                now_reg         <= now_next;
                last_reg        <= last_next;
                mode_reg        <= mode_next;
                window_left_reg <= window_left_next;
                setup_left_reg  <= setup_left_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (process) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ===== test/bhg_gesture_checker.sv =====
`timescale 1ns / 100ps

module bhg_gesture_checker
    import bhg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    input  logic                      s_ready,
    input  in_item_t                  s_data,

    input  logic                      m_valid,
    input  logic                      m_ready,
    input  out_item_t                 m_data,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    output int                        outstanding,
    output int                        fail_count
);

    // Shadow of the gesture state and of the configuration registers.
    logic [TIME_BITS-1:0]    now_ms;
    logic [TIME_BITS-1:0]    last_edge_ms;
    mode_t                   gesture_state;
    logic [TIMER_BITS-1:0]   window_left;
    logic [TIMER_BITS-1:0]   setup_left;
    logic [TIMER_BITS-1:0]   debounce_ms;
    logic [TIMER_BITS-1:0]   long_hold_ms;
    logic [TIMER_BITS-1:0]   window_ms;
    logic [AP_HOLD_BITS-1:0] ap_hold_s;

    out_item_t pending_results[$];

    // A zero length still runs the countdown for one tick.
    function automatic logic [TIMER_BITS-1:0] arm_count(input logic [31:0] ms);
        if (ms == 0) return TIMER_BITS'(1);
        if (ms > 32'hFFFF) return '1;
        return ms[TIMER_BITS-1:0];
    endfunction

    function automatic out_item_t predict_gesture(input in_item_t item);
        out_item_t            res;
        logic [TIME_BITS-1:0] gap;
        logic [31:0]          ap_hold_ms;
        res = '0;
        res.blink_request = BLINK_NONE;
        ap_hold_ms = 32'(ap_hold_s) * 32'(MS_PER_S);
        if (item.opcode == OP_TICK) begin
            now_ms = now_ms + 1'b1;
            if (window_left != 0) begin
                window_left = window_left - 1'b1;
                if (window_left == 0 && gesture_state == MODE_WINDOW) begin
                    gesture_state = MODE_IDLE;
                end
            end
            if (setup_left != 0) begin
                setup_left = setup_left - 1'b1;
                if (setup_left == 0 && gesture_state == MODE_HOLD) begin
                    res.blink_request = BLINK_EIGHT;
                end
            end
        end else begin
            gap = now_ms - last_edge_ms;
            if (gap > debounce_ms) begin
                res.edge_accepted = 1'b1;
                case (gesture_state)
                    MODE_IDLE: begin
                        if (!item.pin_pressed && gap > long_hold_ms) begin
                            gesture_state     = MODE_WINDOW;
                            res.blink_request = BLINK_FOUR;
                            window_left       = arm_count(window_ms);
                        end
                    end
                    MODE_WINDOW: begin
                        if (item.pin_pressed) begin
                            setup_left    = arm_count(ap_hold_ms);
                            gesture_state = MODE_HOLD;
                        end
                    end
                    MODE_HOLD: begin
                        if (!item.pin_pressed && gap > ap_hold_ms) begin
                            res.start_ap  = 1'b1;
                            gesture_state = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
                last_edge_ms = now_ms;
            end
        end
        res.gesture_mode = gesture_state;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            now_ms        = '0;
            last_edge_ms  = '0;
            gesture_state = MODE_IDLE;
            window_left   = '0;
            setup_left    = '0;
            debounce_ms   = DEBOUNCE_RST;
            long_hold_ms  = LONG_HOLD_RST;
            window_ms     = WINDOW_RST;
            ap_hold_s     = AP_HOLD_RST;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE:  debounce_ms  = cfg_data;
                    REG_LONG_HOLD: long_hold_ms = cfg_data;
                    REG_WINDOW:    window_ms    = cfg_data;
                    REG_AP_HOLD:   ap_hold_s    = cfg_data[AP_HOLD_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_gesture(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with none pending: %p", m_data);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("gesture_mode", want.gesture_mode, m_data.gesture_mode);
                    check_field("blink_request", want.blink_request, m_data.blink_request);
                    check_field("start_ap", want.start_ap, m_data.start_ap);
                    check_field("edge_accepted", want.edge_accepted, m_data.edge_accepted);
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== test/tb_button_hold_gesture_fsm.sv =====
`timescale 1ns / 100ps

module tb_button_hold_gesture_fsm;
    import bhg_pkg::*;

    // Cycles without any transaction or register write before the run is
    // declared hung. A correct run never reaches the limit, since idle bursts
    // on each side are bounded.
    localparam int QUIET_LIMIT  = 1000;
    // Extra cycles after the last result before a register write or the end.
    localparam int DRAIN_MARGIN = 4;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_item_t                 m_data;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_DEBOUNCE;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int outstanding;
    int mismatches;

    // Stimulus bookkeeping. The configuration copies only shape the random
    // gestures; prediction lives in the checker.
    bit          idle_on;
    int          stall_left;
    int          quiet_cycles;
    int unsigned items_sent;
    int unsigned debounce_cfg;
    int unsigned long_hold_cfg;
    int unsigned window_cfg;
    int unsigned ap_hold_cfg;

    button_hold_gesture_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bhg_gesture_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (mismatches)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side back-pressure. A stall starts at random and has a random
    // length; with idling switched off the sink always takes results.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: any transaction on either channel, or a register write,
    // restarts the count. A lost result leaves the drain loop waiting
    // forever, so it ends up here as well.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one transaction and returns at the edge where it is taken. The
    // valid stays high on return, so back-to-back calls keep the channel
    // busy; an idle burst, when drawn, lowers it before the next offer.
    task automatic send_item(input logic op, input logic pressed);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, pin_pressed: pressed};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // The pin level is meaningless on a tick, so it is left random there.
    task automatic run_ticks(input int unsigned count);
        repeat (count) send_item(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Every transaction yields exactly one result, so once the checker holds
    // no expectation the block has nothing in flight. The first edge lets the
    // count catch up with a transaction taken at the current edge.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_MARGIN) @(posedge aclk);
    endtask

    // Writes all four registers while the block is idle. The hold time goes
    // in as a full data word, so upper bits beyond its six can be exercised.
    task automatic configure(input logic [CFG_DATA_BITS-1:0] debounce,
                             input logic [CFG_DATA_BITS-1:0] long_hold,
                             input logic [CFG_DATA_BITS-1:0] window_len,
                             input logic [CFG_DATA_BITS-1:0] ap_hold_word);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= debounce;
        @(posedge aclk);
        cfg_index <= REG_LONG_HOLD;
        cfg_data  <= long_hold;
        @(posedge aclk);
        cfg_index <= REG_WINDOW;
        cfg_data  <= window_len;
        @(posedge aclk);
        cfg_index <= REG_AP_HOLD;
        cfg_data  <= ap_hold_word;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        debounce_cfg  = 32'(debounce);
        long_hold_cfg = 32'(long_hold);
        window_cfg    = 32'(window_len);
        ap_hold_cfg   = 32'(ap_hold_word[AP_HOLD_BITS-1:0]);
    endtask

    // One pass of the full gesture with random timing: press and hold around
    // the long-hold threshold, release, wait some part of the window, press
    // again and hold around the setup time, then release. The random spans
    // straddle every threshold, so some passes complete and some fall short
    // or bounce inside the debounce gap.
    task automatic gesture_round();
        int unsigned hold_ms;
        hold_ms = ap_hold_cfg * 1000;
        run_ticks($urandom_range(0, debounce_cfg + 2));
        send_item(OP_EDGE, 1'b1);
        run_ticks($urandom_range(0, long_hold_cfg + debounce_cfg + 4));
        send_item(OP_EDGE, 1'b0);
        run_ticks($urandom_range(0, window_cfg + 4));
        send_item(OP_EDGE, 1'b1);
        if (hold_ms == 0) begin
            run_ticks($urandom_range(0, debounce_cfg + 4));
        end else begin
            run_ticks($urandom_range(hold_ms - 3, hold_ms + 3));
        end
        send_item(OP_EDGE, 1'b0);
    endtask

    // Arbitrary transactions with no gesture structure behind them.
    task automatic noise_burst();
        repeat ($urandom_range(1, 8)) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int          phase;
        int unsigned budget;
        int unsigned start_count;

        idle_on = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: the debounce gap of 150 ms rejects edges right away.
        send_item(OP_EDGE, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b0);

        // All lengths zero; the hold time word carries only upper bits, which
        // the register drops. A gap equal to the debounce setting is still
        // rejected, and a zero length window closes on the very next tick.
        configure(16'd0, 16'd0, 16'd0, 16'hFFC0);
        send_item(OP_EDGE, 1'b1);
        send_item(OP_EDGE, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_EDGE, 1'b0);
        send_item(OP_TICK, 1'b0);

        // A short window: open it, release inside it (no effect), press to
        // enter hold mode, let the zero length setup timer fire the eight
        // blink burst while the window timer runs out in hold mode, press
        // again in hold mode, and release to request access point setup.
        configure(16'd0, 16'd0, 16'd3, 16'd0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b0);
        send_item(OP_EDGE, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_EDGE, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_EDGE, 1'b0);

        // A release exactly at the long-hold time does not open the window;
        // one tick more does. The setup timer then runs its full second and
        // a release just past it starts setup, with the window timer still
        // running.
        configure(16'd0, 16'd20, 16'd1020, 16'd1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b0);
        run_ticks(20);
        send_item(OP_EDGE, 1'b0);
        run_ticks(21);
        send_item(OP_EDGE, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b1);
        run_ticks(1000);
        send_item(OP_TICK, 1'b1);
        send_item(OP_EDGE, 1'b0);

        // Debounce boundary: rejected at zero and at exactly the setting,
        // accepted one tick later. The leftover window timer expires in idle
        // mode on the way and must change nothing.
        configure(16'd40, 16'd40, 16'd1020, 16'd1);
        send_item(OP_EDGE, 1'b1);
        run_ticks(40);
        send_item(OP_EDGE, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_EDGE, 1'b1);

        // Random part. Each phase draws short lengths so that gestures run to
        // completion often; one phase uses a zero length window. The final
        // phase runs without idling.
        for (phase = 0; phase < 8; phase++) begin
            configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 12)),
                      (phase == 2) ? 16'd0 : 16'($urandom_range(1, 20)),
                      16'd0);
            idle_on     = (phase != 7) && ($urandom_range(0, 3) != 0);
            budget      = 10;
            start_count = items_sent;
            while (items_sent - start_count < budget) begin
                if ($urandom_range(0, 4) == 0) begin
                    noise_burst();
                end else begin
                    gesture_round();
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
